// ----- hdl/cos2fit_pkg.sv -----
// shared types, constants and table helper for the cos2 model fit cost accumulator
package cos2fit_pkg;

   localparam int TRIG_TABLE_DEPTH_DEFAULT = 1024;

   localparam longint unsigned PI_Q28      = 64'd843314857;
   localparam longint unsigned TWO_PI_Q28  = 64'd1686629713;
   localparam longint unsigned HALF_PI_Q28 = PI_Q28 / 2;

   localparam int ANGLE_BITS  = 16;
   localparam int COUNT_BITS  = 32;
   localparam int SIGMA_BITS  = 24;
   localparam int AMP_BITS    = 11;
   localparam int OFFSET_BITS = 21;
   localparam int SUM_BITS    = 64;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int UNIT_BITS   = 128;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_AMP_ROOT    = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_OFFSET      = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WINDOW_LOW  = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WINDOW_HIGH = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COST_MODE   = 3'd4;

   typedef enum logic [1:0] {
      MODE_CHI2_ERR = 2'd0,
      MODE_LSQ      = 2'd1,
      MODE_PEARSON  = 2'd2,
      MODE_TLS      = 2'd3
   } cost_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PHASE,
      ST_ROM,
      ST_AMP,
      ST_EC,
      ST_R2,
      ST_MODE,
      ST_SIGSQ,
      ST_SLOPE,
      ST_SLOPESQ,
      ST_QUOT,
      ST_ACCUM,
      ST_EMIT
   } state_type;

   // restoring quotient for table construction
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 1) | 64'(num[i]);
         if (rem >= den) begin
            rem = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // q28 taylor series rounded to q14, odd selects sine
   function automatic logic signed [15:0] series_q14(input longint unsigned t, input bit odd);
      longint unsigned t2;
      longint unsigned term;
      longint unsigned mag;
      longint          sum;
      int unsigned     n;
      bit              neg;
      t2   = (t * t) >> 28;
      term = odd ? t : (64'd1 << 28);
      n    = odd ? 1 : 0;
      sum  = longint'(term);
      neg  = 1'b1;
      for (int i = 0; i < 14; i++) begin
         term = udiv64((term * t2) >> 28, 64'((n + 1) * (n + 2)));
         n    = n + 2;
         sum  = neg ? sum - longint'(term) : sum + longint'(term);
         neg  = !neg;
      end
      mag = longint'(sum < 0 ? -sum : sum);
      mag = (mag + 64'd8192) >> 14;
      if (mag > 64'd16384) mag = 64'd16384;
      return sum < 0 ? -16'(mag) : 16'(mag);
   endfunction

endpackage

// ----- hdl/cos2fit_req_if.sv -----
// bin input channel
interface cos2fit_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [cos2fit_pkg::ANGLE_BITS-1:0] bin_angle;
   logic signed [cos2fit_pkg::COUNT_BITS-1:0] bin_count;
   logic [cos2fit_pkg::SIGMA_BITS-1:0]        bin_sigma;
   logic                                      last_bin;
   modport source (output valid, bin_angle, bin_count, bin_sigma, last_bin, input ready);
   modport sink (input valid, bin_angle, bin_count, bin_sigma, last_bin, output ready);
endinterface

// ----- hdl/cos2fit_rsp_if.sv -----
// cost result channel
interface cos2fit_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [cos2fit_pkg::SUM_BITS-1:0] cost_sum;
   logic                                    divide_fault;
   logic                                    saturated;
   modport source (output valid, cost_sum, divide_fault, saturated, input ready);
   modport sink (input valid, cost_sum, divide_fault, saturated, output ready);
endinterface

// ----- hdl/cos2fit_csr_if.sv -----
// register write channel
interface cos2fit_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [cos2fit_pkg::CSR_ADDR_BITS-1:0]  addr;
   logic [cos2fit_pkg::CSR_DATA_BITS-1:0]  wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

// ----- hdl/cos2_model_fit_cost_accumulator_core.sv -----
// top level: bin scoring against amp^2*cos(2x)+offset with a saturating cost sum
//
//  channel  dir  transfer when     payload
//  req_ch   in   valid && ready    bin_angle, bin_count, bin_sigma, last_bin
//  rsp_ch   out  valid && ready    cost_sum, divide_fault, saturated
//  csr_ch   in   valid && ready    addr, wdata (always ready)
//
// a scored bin holds req off until its term is added, or dropped when the divisor
// is zero in error-weighted chi2 or pearson mode: one shared 128 bit add/subtract
// unit runs every multiply bit by bit and every division as a restoring loop
// a bin strictly between the window bounds is not scored; a last bin passes through emit to load rsp
// reset is synchronous; req is held off while a new result waits on a stalled rsp
module cos2_model_fit_cost_accumulator_core #(
   parameter int TRIG_TABLE_DEPTH = cos2fit_pkg::TRIG_TABLE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   cos2fit_req_if.sink        req_ch,
   cos2fit_rsp_if.source      rsp_ch,
   cos2fit_csr_if.sink        csr_ch
);

   localparam int UB = cos2fit_pkg::UNIT_BITS;
   localparam int IW = $clog2(TRIG_TABLE_DEPTH);
   localparam int PW = 34 + IW;
   localparam int QW = $clog2(3 * TRIG_TABLE_DEPTH) + 1;

   typedef logic signed [15:0] trig_row_type [TRIG_TABLE_DEPTH];

   function automatic trig_row_type build_table(input bit odd);
      trig_row_type    rows;
      bit              upper;
      longint unsigned kk;
      longint unsigned t;
      logic signed [15:0] v;
      for (int k = 0; k < TRIG_TABLE_DEPTH; k++) begin
         upper = (2 * k) > TRIG_TABLE_DEPTH;
         kk    = upper ? longint'(TRIG_TABLE_DEPTH - k) : longint'(k);
         t     = kk * cos2fit_pkg::TWO_PI_Q28 / TRIG_TABLE_DEPTH;
         v     = cos2fit_pkg::series_q14(t, odd);
         rows[k] = (odd && upper) ? -v : v;
      end
      return rows;
   endfunction

   localparam trig_row_type COS_TABLE = build_table(1'b0);
   localparam trig_row_type SIN_TABLE = build_table(1'b1);

   // configuration
   logic [cos2fit_pkg::AMP_BITS-1:0]           amp_root_ff;
   logic signed [cos2fit_pkg::OFFSET_BITS-1:0] offset_ff;
   logic signed [15:0]                         window_low_ff;
   logic signed [15:0]                         window_high_ff;
   cos2fit_pkg::cost_mode_type                 cost_mode_ff;

   // bin and working registers
   logic signed [15:0]  angle_ff;
   logic signed [31:0]  count_ff;
   logic [23:0]         sigma_ff;
   logic                last_ff;
   logic signed [15:0]  cos_ff;
   logic signed [15:0]  sin_ff;
   logic [21:0]         amp_ff;
   logic signed [39:0]  e_ff;
   logic [95:0]         r2_ff;

   // shared unit
   logic [UB-1:0] acc_ff;
   logic [UB-1:0] opa_ff;
   logic [UB-1:0] opb_ff;
   logic [7:0]    cnt_ff;
   logic          ld_ff;
   logic          ld_in;

   logic signed [63:0] running_ff;
   logic               fault_ff;
   logic               sat_ff;

   logic               rsp_valid_ff;
   logic signed [63:0] rsp_sum_ff;
   logic               rsp_fault_ff;
   logic               rsp_sat_ff;

   cos2fit_pkg::state_type state_ff, state_in;

   logic req_take;
   logic scored;
   logic finish_last;

   assign req_take = req_ch.valid && req_ch.ready;
   assign scored = (req_ch.bin_angle <= window_low_ff) || (req_ch.bin_angle >= window_high_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cos2fit_pkg::ST_IDLE: begin
            if (req_take) begin
               if (scored) state_in = cos2fit_pkg::ST_PHASE;
               else if (req_ch.last_bin) state_in = cos2fit_pkg::ST_EMIT;
            end
         end
         cos2fit_pkg::ST_PHASE: begin
            if (!ld_ff && cnt_ff == 8'd1) state_in = cos2fit_pkg::ST_ROM;
         end
         cos2fit_pkg::ST_ROM: state_in = cos2fit_pkg::ST_AMP;
         cos2fit_pkg::ST_AMP: begin
            if (!ld_ff && cnt_ff == 8'd1) state_in = cos2fit_pkg::ST_EC;
         end
         cos2fit_pkg::ST_EC: begin
            if (!ld_ff && cnt_ff == 8'd1) state_in = cos2fit_pkg::ST_R2;
         end
         cos2fit_pkg::ST_R2: begin
            if (!ld_ff && cnt_ff == 8'd1) state_in = cos2fit_pkg::ST_MODE;
         end
         cos2fit_pkg::ST_MODE: begin
            case (cost_mode_ff)
               cos2fit_pkg::MODE_LSQ: state_in = cos2fit_pkg::ST_ACCUM;
               cos2fit_pkg::MODE_CHI2_ERR: begin
                  if (sigma_ff == '0) state_in = finish_last ? cos2fit_pkg::ST_EMIT
                                                             : cos2fit_pkg::ST_IDLE;
                  else state_in = cos2fit_pkg::ST_SIGSQ;
               end
               cos2fit_pkg::MODE_PEARSON: begin
                  if (e_ff == '0) state_in = finish_last ? cos2fit_pkg::ST_EMIT
                                                         : cos2fit_pkg::ST_IDLE;
                  else state_in = cos2fit_pkg::ST_QUOT;
               end
               default: state_in = cos2fit_pkg::ST_SLOPE;
            endcase
         end
         cos2fit_pkg::ST_SIGSQ: begin
            if (!ld_ff && cnt_ff == 8'd1) state_in = cos2fit_pkg::ST_QUOT;
         end
         cos2fit_pkg::ST_SLOPE: begin
            if (!ld_ff && cnt_ff == 8'd1) state_in = cos2fit_pkg::ST_SLOPESQ;
         end
         cos2fit_pkg::ST_SLOPESQ: begin
            if (!ld_ff && cnt_ff == 8'd1) state_in = cos2fit_pkg::ST_QUOT;
         end
         cos2fit_pkg::ST_QUOT: begin
            if (!ld_ff && cnt_ff == 8'd1) state_in = cos2fit_pkg::ST_ACCUM;
         end
         cos2fit_pkg::ST_ACCUM: begin
            state_in = finish_last ? cos2fit_pkg::ST_EMIT : cos2fit_pkg::ST_IDLE;
         end
         cos2fit_pkg::ST_EMIT: begin
            if (!rsp_valid_ff) state_in = cos2fit_pkg::ST_IDLE;
         end
         default: state_in = cos2fit_pkg::ST_IDLE;
      endcase
   end

   assign ld_in = (state_in != state_ff);
   assign finish_last = last_ff;

   // outputs
   always_comb begin
      req_ch.ready = (state_ff == cos2fit_pkg::ST_IDLE);
      csr_ch.ready = 1'b1;
      rsp_ch.valid = rsp_valid_ff;
      rsp_ch.cost_sum = rsp_sum_ff;
      rsp_ch.divide_fault = rsp_fault_ff;
      rsp_ch.saturated = rsp_sat_ff;
   end

   // shared add/subtract unit
   logic           unit_sub;
   logic [UB-1:0]  unit_x;
   logic [UB:0]    unit_sum;
   logic           unit_no_borrow;

   assign unit_sub = (state_ff == cos2fit_pkg::ST_PHASE) || (state_ff == cos2fit_pkg::ST_QUOT);
   assign unit_x = unit_sub ? {acc_ff[UB-2:0], opa_ff[UB-1]} : acc_ff;
   assign unit_sum = {1'b0, unit_x} + {1'b0, (unit_sub ? ~opb_ff : opa_ff)}
                     + {{UB{1'b0}}, unit_sub};
   assign unit_no_borrow = unit_sum[UB];

   // phase index
   logic [15:0]    angle_mag;
   logic [PW-1:0]  phase_num;
   logic [QW-1:0]  q_val;
   logic [QW-1:0]  q_red;
   logic [IW-1:0]  p_idx;
   logic [IW:0]    p_neg;

   assign angle_mag = angle_ff[15] ? 16'(-angle_ff) : 16'(angle_ff);
   assign phase_num = ((PW'(angle_mag) * PW'(TRIG_TABLE_DEPTH)) << 16)
                      + PW'(cos2fit_pkg::HALF_PI_Q28);
   assign q_val = opa_ff[QW-1:0];
   always_comb begin
      if (q_val >= QW'(2 * TRIG_TABLE_DEPTH)) q_red = q_val - QW'(2 * TRIG_TABLE_DEPTH);
      else if (q_val >= QW'(TRIG_TABLE_DEPTH)) q_red = q_val - QW'(TRIG_TABLE_DEPTH);
      else q_red = q_val;
   end
   assign p_neg = (IW + 1)'(TRIG_TABLE_DEPTH) - (IW + 1)'(q_red);
   assign p_idx = (angle_ff[15] && q_red != '0) ? p_neg[IW-1:0] : q_red[IW-1:0];

   // model value and residual
   logic [36:0]         ec_mag;
   logic signed [39:0]  e_val;
   logic signed [47:0]  r_val;
   logic [47:0]         r_mag;
   logic [14:0]         cos_mag;
   logic [14:0]         sin_mag;
   logic [37:0]         slope;

   assign cos_mag = cos_ff[15] ? 15'(-cos_ff) : 15'(cos_ff);
   assign sin_mag = sin_ff[15] ? 15'(-sin_ff) : 15'(sin_ff);
   assign ec_mag = acc_ff[36:0];
   assign e_val = (cos_ff[15] ? -40'(ec_mag) : 40'(ec_mag))
                  + (40'(offset_ff) <<< 14);
   assign r_val = 48'(e_val) - (48'(count_ff) <<< 14);
   assign r_mag = r_val[47] ? 48'(-r_val) : 48'(r_val);
   assign slope = {acc_ff[36:0], 1'b0};

   // term and saturating sum
   logic               term_clamp;
   logic signed [63:0] term_mag;
   logic signed [63:0] term_val;
   logic signed [64:0] sum_wide;
   logic               sum_ovf;

   assign term_clamp = (opa_ff[UB-1:63] != '0);
   assign term_mag = term_clamp ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(opa_ff[63:0]);
   assign term_val = (cost_mode_ff == cos2fit_pkg::MODE_PEARSON && e_ff < 0)
                     ? -term_mag : term_mag;
   assign sum_wide = 65'(running_ff) + 65'(term_val);
   assign sum_ovf = (sum_wide[64] != sum_wide[63]);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cos2fit_pkg::ST_IDLE;
         ld_ff <= 1'b0;
         cnt_ff <= '0;
         running_ff <= '0;
         fault_ff <= 1'b0;
         sat_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         amp_root_ff <= 11'd100;
         offset_ff <= '0;
         window_low_ff <= '0;
         window_high_ff <= '0;
         cost_mode_ff <= cos2fit_pkg::MODE_CHI2_ERR;
      end else begin
         state_ff <= state_in;
         ld_ff <= ld_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.addr)
               cos2fit_pkg::CSR_AMP_ROOT:    amp_root_ff <= csr_ch.wdata[10:0];
               cos2fit_pkg::CSR_OFFSET:      offset_ff <= $signed(csr_ch.wdata[20:0]);
               cos2fit_pkg::CSR_WINDOW_LOW:  window_low_ff <= $signed(csr_ch.wdata[15:0]);
               cos2fit_pkg::CSR_WINDOW_HIGH: window_high_ff <= $signed(csr_ch.wdata[15:0]);
               cos2fit_pkg::CSR_COST_MODE:
                  cost_mode_ff <= cos2fit_pkg::cost_mode_type'(csr_ch.wdata[1:0]);
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ch.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            cos2fit_pkg::ST_PHASE: cnt_ff <= ld_ff ? 8'(PW) : cnt_ff - 8'd1;
            cos2fit_pkg::ST_AMP:   cnt_ff <= ld_ff ? 8'd11 : cnt_ff - 8'd1;
            cos2fit_pkg::ST_EC:    cnt_ff <= ld_ff ? 8'd15 : cnt_ff - 8'd1;
            cos2fit_pkg::ST_R2:    cnt_ff <= ld_ff ? 8'd48 : cnt_ff - 8'd1;
            cos2fit_pkg::ST_SIGSQ: cnt_ff <= ld_ff ? 8'd24 : cnt_ff - 8'd1;
            cos2fit_pkg::ST_SLOPE: cnt_ff <= ld_ff ? 8'd15 : cnt_ff - 8'd1;
            cos2fit_pkg::ST_SLOPESQ: cnt_ff <= ld_ff ? 8'd38 : cnt_ff - 8'd1;
            cos2fit_pkg::ST_QUOT:  cnt_ff <= ld_ff ? 8'(UB) : cnt_ff - 8'd1;
            cos2fit_pkg::ST_MODE: begin
               if ((cost_mode_ff == cos2fit_pkg::MODE_CHI2_ERR && sigma_ff == '0) ||
                   (cost_mode_ff == cos2fit_pkg::MODE_PEARSON && e_ff == '0))
                  fault_ff <= 1'b1;
            end
            cos2fit_pkg::ST_ACCUM: begin
               if (term_clamp) sat_ff <= 1'b1;
               if (sum_ovf) begin
                  running_ff <= term_val[63] ? 64'sh8000_0000_0000_0000
                                             : 64'sh7FFF_FFFF_FFFF_FFFF;
                  sat_ff <= 1'b1;
               end else begin
                  running_ff <= sum_wide[63:0];
               end
            end
            cos2fit_pkg::ST_EMIT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  running_ff <= '0;
                  fault_ff <= 1'b0;
                  sat_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         angle_ff <= req_ch.bin_angle;
         count_ff <= req_ch.bin_count;
         sigma_ff <= req_ch.bin_sigma;
         last_ff <= req_ch.last_bin;
      end
      if (state_ff == cos2fit_pkg::ST_EMIT && !rsp_valid_ff) begin
         rsp_sum_ff <= running_ff;
         rsp_fault_ff <= fault_ff;
         rsp_sat_ff <= sat_ff;
      end
      case (state_ff)
         cos2fit_pkg::ST_PHASE, cos2fit_pkg::ST_QUOT: begin
            if (ld_ff) begin
               acc_ff <= '0;
               if (state_ff == cos2fit_pkg::ST_PHASE) begin
                  opa_ff <= {phase_num, {(UB - PW){1'b0}}};
                  opb_ff <= UB'(cos2fit_pkg::PI_Q28);
               end else begin
                  case (cost_mode_ff)
                     cos2fit_pkg::MODE_CHI2_ERR: begin
                        opa_ff <= UB'(r2_ff) << 4;
                        opb_ff <= acc_ff;
                     end
                     cos2fit_pkg::MODE_PEARSON: begin
                        opa_ff <= UB'(r2_ff) << 2;
                        opb_ff <= UB'(e_ff[39] ? 40'(-e_ff) : 40'(e_ff));
                     end
                     default: begin
                        opa_ff <= UB'(r2_ff) << 16;
                        opb_ff <= acc_ff + (UB'(1) << 28);
                     end
                  endcase
               end
            end else begin
               acc_ff <= unit_no_borrow ? unit_sum[UB-1:0] : unit_x;
               opa_ff <= {opa_ff[UB-2:0], unit_no_borrow};
            end
         end
         cos2fit_pkg::ST_ROM: begin
            cos_ff <= COS_TABLE[p_idx];
            sin_ff <= SIN_TABLE[p_idx];
         end
         cos2fit_pkg::ST_AMP, cos2fit_pkg::ST_EC, cos2fit_pkg::ST_R2, cos2fit_pkg::ST_SIGSQ,
         cos2fit_pkg::ST_SLOPE, cos2fit_pkg::ST_SLOPESQ: begin
            if (ld_ff) begin
               acc_ff <= '0;
               case (state_ff)
                  cos2fit_pkg::ST_AMP: begin
                     opa_ff <= UB'(amp_root_ff);
                     opb_ff <= UB'(amp_root_ff);
                  end
                  cos2fit_pkg::ST_EC: begin
                     amp_ff <= acc_ff[21:0];
                     opa_ff <= UB'(acc_ff[21:0]);
                     opb_ff <= UB'(cos_mag);
                  end
                  cos2fit_pkg::ST_R2: begin
                     e_ff <= e_val;
                     opa_ff <= UB'(r_mag);
                     opb_ff <= UB'(r_mag);
                  end
                  cos2fit_pkg::ST_SIGSQ: begin
                     opa_ff <= UB'(sigma_ff);
                     opb_ff <= UB'(sigma_ff);
                  end
                  cos2fit_pkg::ST_SLOPE: begin
                     opa_ff <= UB'(amp_ff);
                     opb_ff <= UB'(sin_mag);
                  end
                  default: begin
                     opa_ff <= UB'(slope);
                     opb_ff <= UB'(slope);
                  end
               endcase
            end else begin
               if (opb_ff[0]) acc_ff <= unit_sum[UB-1:0];
               opa_ff <= {opa_ff[UB-2:0], 1'b0};
               opb_ff <= {1'b0, opb_ff[UB-1:1]};
            end
         end
         cos2fit_pkg::ST_MODE: begin
            r2_ff <= acc_ff[95:0];
            if (cost_mode_ff == cos2fit_pkg::MODE_LSQ) opa_ff <= acc_ff >> 12;
         end
         default: ;
      endcase
   end

   // checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> state_ff == cos2fit_pkg::ST_IDLE)
      else $error("req ready outside idle");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == cos2fit_pkg::ST_EMIT)
      else $error("result raised outside emit");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cos2fit_pkg::ST_QUOT && !ld_ff) |-> cnt_ff != 8'd0)
      else $error("division step with exhausted count");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cos2fit_pkg::ST_EMIT && !rsp_valid_ff) |=>
         (running_ff == '0 && !fault_ff && !sat_ff && rsp_valid_ff))
      else $error("emit did not clear the sum");

endmodule

// ----- bench/tb.sv -----
// self-checking bench for the cos2 model fit cost accumulator: random bins, cost model, scoreboard
`timescale 1ns / 1ps

typedef struct {
   logic signed [63:0] cost_sum;
   logic               divide_fault;
   logic               saturated;
} cost_result_type;

class cost_scoreboard;
   localparam int DEPTH = cos2fit_pkg::TRIG_TABLE_DEPTH_DEFAULT;
   logic signed [15:0] cos_tab [DEPTH];
   logic signed [15:0] sin_tab [DEPTH];
   logic [10:0]        amp_root;
   logic signed [20:0] offset;
   logic signed [15:0] window_low;
   logic signed [15:0] window_high;
   cos2fit_pkg::cost_mode_type cost_mode;
   longint             running_cost;
   bit                 fault_seen;
   bit                 sat_seen;
   cost_result_type    pending_sums[$];
   int                 mismatches;

   function new();
      longint unsigned kk, t;
      bit upper;
      for (int k = 0; k < DEPTH; k++) begin
         upper = 2 * k > DEPTH;
         kk = upper ? DEPTH - k : k;
         t = kk * cos2fit_pkg::TWO_PI_Q28 / DEPTH;
         cos_tab[k] = taylor_q14(t, 1'b0);
         sin_tab[k] = upper ? -taylor_q14(t, 1'b1) : taylor_q14(t, 1'b1);
      end
      amp_root = 11'd100;
      offset = '0;
      window_low = '0;
      window_high = '0;
      cost_mode = cos2fit_pkg::MODE_CHI2_ERR;
      running_cost = 0;
      fault_seen = 0;
      sat_seen = 0;
      mismatches = 0;
   endfunction

   function logic signed [15:0] taylor_q14(longint unsigned t, bit odd);
      longint unsigned t2, term, mag, n;
      longint acc;
      bit neg;
      t2 = (t * t) >> 28;
      term = odd ? t : (64'd1 << 28);
      n = odd ? 64'd1 : 64'd0;
      acc = longint'(term);
      neg = 1;
      for (int i = 0; i < 14; i++) begin
         term = ((term * t2) >> 28) / ((n + 1) * (n + 2));
         n += 2;
         acc = neg ? acc - longint'(term) : acc + longint'(term);
         neg = !neg;
      end
      mag = acc < 0 ? -acc : acc;
      mag = (mag + 8192) >> 14;
      if (mag > 16384) mag = 16384;
      return acc < 0 ? -16'(mag) : 16'(mag);
   endfunction

   function void write_reg(logic [cos2fit_pkg::CSR_ADDR_BITS-1:0] idx, logic [31:0] wdata);
      case (idx)
         cos2fit_pkg::CSR_AMP_ROOT:    amp_root = wdata[10:0];
         cos2fit_pkg::CSR_OFFSET:      offset = wdata[20:0];
         cos2fit_pkg::CSR_WINDOW_LOW:  window_low = wdata[15:0];
         cos2fit_pkg::CSR_WINDOW_HIGH: window_high = wdata[15:0];
         cos2fit_pkg::CSR_COST_MODE:   cost_mode = cos2fit_pkg::cost_mode_type'(wdata[1:0]);
         default: ;
      endcase
   endfunction

   function void add_term(logic [127:0] q, bit negate);
      logic signed [64:0] total;
      longint term;
      if (q > 128'h7FFF_FFFF_FFFF_FFFF) begin
         sat_seen = 1;
         term = 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
         term = q[63:0];
      end
      if (negate) term = -term;
      total = 65'(running_cost) + 65'(term);
      if (total > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
         running_cost = 64'h7FFF_FFFF_FFFF_FFFF;
         sat_seen = 1;
      end else if (total < -65'sh0_8000_0000_0000_0000) begin
         running_cost = 64'h8000_0000_0000_0000;
         sat_seen = 1;
      end else begin
         running_cost = total[63:0];
      end
   endfunction

   function void score_bin(longint a, longint y, longint unsigned sg);
      longint unsigned mg, p;
      longint amp, e, r, c, s;
      logic [127:0] rm, r2, den, slope;
      mg = a < 0 ? -a : a;
      p = ((mg * DEPTH * 65536 + cos2fit_pkg::PI_Q28 / 2) / cos2fit_pkg::PI_Q28) % DEPTH;
      if (a < 0) p = (DEPTH - p) % DEPTH;
      c = cos_tab[p];
      s = sin_tab[p];
      amp = longint'(amp_root) * longint'(amp_root);
      e = amp * c + longint'(offset) * 16384;
      r = e - y * 16384;
      rm = 128'(r < 0 ? -r : r);
      r2 = rm * rm;
      case (cost_mode)
         cos2fit_pkg::MODE_CHI2_ERR: begin
            if (sg == 0) begin
               fault_seen = 1;
               return;
            end
            den = 128'(sg) * 128'(sg);
            add_term((r2 << 4) / den, 0);
         end
         cos2fit_pkg::MODE_LSQ: add_term(r2 >> 12, 0);
         cos2fit_pkg::MODE_PEARSON: begin
            if (e == 0) begin
               fault_seen = 1;
               return;
            end
            den = 128'(e < 0 ? -e : e);
            add_term((r2 << 2) / den, e < 0);
         end
         default: begin
            slope = 128'(2 * amp) * 128'(s < 0 ? -s : s);
            den = slope * slope + (128'd1 << 28);
            add_term((r2 << 16) / den, 0);
         end
      endcase
   endfunction

   function void note_bin(logic signed [15:0] a, logic signed [31:0] y, logic [23:0] sg,
                          logic lst);
      cost_result_type res;
      if (a <= window_low || a >= window_high) score_bin(a, y, sg);
      if (lst) begin
         res.cost_sum = running_cost;
         res.divide_fault = fault_seen;
         res.saturated = sat_seen;
         pending_sums.push_back(res);
         running_cost = 0;
         fault_seen = 0;
         sat_seen = 0;
      end
   endfunction

   function void check_result(logic signed [63:0] sum, logic fault, logic sat);
      cost_result_type exp_res;
      if (pending_sums.size() == 0) begin
         $error("unexpected result cost_sum=%0d", sum);
         mismatches++;
         return;
      end
      exp_res = pending_sums.pop_front();
      if (sum !== exp_res.cost_sum) begin
         $error("cost_sum expected %0d actual %0d", exp_res.cost_sum, sum);
         mismatches++;
      end
      if (fault !== exp_res.divide_fault) begin
         $error("divide_fault expected %0d actual %0d", exp_res.divide_fault, fault);
         mismatches++;
      end
      if (sat !== exp_res.saturated) begin
         $error("saturated expected %0d actual %0d", exp_res.saturated, sat);
         mismatches++;
      end
   endfunction
endclass

module tb;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int     SETTLE_CYCLES = 400;

   logic clock;
   logic reset;
   longint cycle_count;
   int burst_left;
   int stall_mode;
   int stall_left;
   cost_scoreboard cost_sb;

   cos2fit_req_if req_ch();
   cos2fit_rsp_if rsp_ch();
   cos2fit_csr_if csr_ch();

   cos2_model_fit_cost_accumulator_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(5, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
         default: rsp_ch.ready <= (stall_left[3:0] > 4'd5);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         cost_sb.check_result(rsp_ch.cost_sum, rsp_ch.divide_fault, rsp_ch.saturated);
   end

   task automatic write_csr(logic [cos2fit_pkg::CSR_ADDR_BITS-1:0] idx, logic [31:0] wdata);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.addr <= idx;
      csr_ch.wdata <= wdata;
      do @(posedge clock); while (!csr_ch.ready);
      cost_sb.write_reg(idx, wdata);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_bin(logic signed [15:0] a, logic signed [31:0] y, logic [23:0] sg,
                           logic lst);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.bin_angle <= a;
      req_ch.bin_count <= y;
      req_ch.bin_sigma <= sg;
      req_ch.last_bin <= lst;
      do @(posedge clock); while (!req_ch.ready);
      cost_sb.note_bin(a, y, sg, lst);
   endtask

   task automatic drain;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (cost_sb.pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_bin(logic lst);
      logic signed [15:0] a;
      logic signed [31:0] y;
      logic [23:0] sg;
      a = $urandom_range(0, 2) == 0
          ? 16'($signed(cost_sb.window_low) + $signed(16'($urandom_range(0, 64))) - 32)
          : 16'($urandom);
      case ($urandom_range(0, 3))
         0: y = $urandom;
         1: y = 32'($signed(32'($urandom_range(0, 2000))) - 1000);
         2: y = 32'(longint'(cost_sb.amp_root) * cost_sb.amp_root / 2 + cost_sb.offset);
         default: y = 32'($signed(32'($urandom_range(0, 4000000))) - 2000000);
      endcase
      case ($urandom_range(0, 7))
         0: sg = '0;
         1, 2: sg = 24'($urandom_range(1, 2048));
         default: sg = 24'($urandom);
      endcase
      send_bin(a, y, sg, lst);
   endtask

   task automatic run_phase(int n_items);
      int left;
      int seq_len;
      left = n_items;
      while (left > 0) begin
         seq_len = $urandom_range(1, 10);
         for (int i = 0; i < seq_len; i++) send_random_bin(i == seq_len - 1);
         left -= seq_len;
      end
      drain();
   endtask

   task automatic set_all(logic [10:0] amp, logic [20:0] off, logic [15:0] wlo,
                          logic [15:0] whi, cos2fit_pkg::cost_mode_type mode);
      write_csr(cos2fit_pkg::CSR_AMP_ROOT, 32'(amp));
      write_csr(cos2fit_pkg::CSR_OFFSET, 32'(off));
      write_csr(cos2fit_pkg::CSR_WINDOW_LOW, 32'(wlo));
      write_csr(cos2fit_pkg::CSR_WINDOW_HIGH, 32'(whi));
      write_csr(cos2fit_pkg::CSR_COST_MODE, 32'(mode));
   endtask

   initial begin
      cost_sb = new();
      cycle_count = 0;
      burst_left = 0;
      stall_mode = 0;
      stall_left = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.bin_angle = '0;
      req_ch.bin_count = '0;
      req_ch.bin_sigma = '0;
      req_ch.last_bin = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.addr = '0;
      csr_ch.wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: error-weighted chi2, edge values and zero sigma
      send_bin(16'sd0, 32'sd10000, 24'd256, 1'b0);
      send_bin(16'sh7FFF, 32'sh7FFF_FFFF, 24'hFF_FFFF, 1'b0);
      send_bin(16'sh8000, 32'sh8000_0000, 24'd1, 1'b0);
      send_bin(16'sd1000, 32'sd5, 24'd0, 1'b1);
      send_bin(16'sh8000, 32'sh7FFF_FFFF, 24'd1, 1'b0);
      send_bin(16'sh8000, 32'sh7FFF_FFFF, 24'd1, 1'b0);
      send_bin(16'sh8000, 32'sh7FFF_FFFF, 24'd1, 1'b1);
      drain();
      set_all(11'd0, 21'd0, 16'sh8000, 16'sh7FFF, cos2fit_pkg::MODE_PEARSON);
      send_bin(16'sh8000, 32'sd7, 24'd3, 1'b0);
      send_bin(16'sd5, 32'sd7, 24'd3, 1'b0);
      send_bin(16'sh7FFF, -32'sd7, 24'd3, 1'b1);
      drain();
      set_all(11'd2047, 21'h10_0000, 16'sd100, -16'sd100, cos2fit_pkg::MODE_PEARSON);
      send_bin(16'sd0, 32'sd0, 24'd0, 1'b0);
      send_bin(16'sd6434, -32'sd1, 24'd0, 1'b1);
      drain();
      set_all(11'd2047, 21'h0F_FFFF, 16'sd0, 16'sd0, cos2fit_pkg::MODE_LSQ);
      send_bin(16'sd0, 32'sh8000_0000, 24'd0, 1'b0);
      send_bin(16'sd0, 32'sh8000_0000, 24'd0, 1'b0);
      send_bin(16'sd3217, 32'sh7FFF_FFFF, 24'd0, 1'b1);
      drain();
      set_all(11'd2047, 21'h10_0000, -16'sd3000, 16'sd3000, cos2fit_pkg::MODE_TLS);
      send_bin(16'sd3217, 32'sd1, 24'd0, 1'b0);
      send_bin(16'sd0, 32'sd1, 24'd0, 1'b0);
      send_bin(-16'sd3217, 32'sh8000_0000, 24'd0, 1'b1);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: set_all(11'($urandom), 21'($urandom), 16'($urandom), 16'($urandom),
                       cos2fit_pkg::cost_mode_type'(ph / 4 % 4));
            1: set_all(11'($urandom_range(0, 200)), 21'($signed(21'($urandom_range(0, 2000)))
                       - 1000), -16'sd4000, 16'sd4000, cos2fit_pkg::MODE_TLS);
            2: set_all(11'($urandom_range(1, 2047)), 21'($urandom), 16'($urandom),
                       16'($urandom), cos2fit_pkg::MODE_PEARSON);
            default: set_all(11'($urandom), 21'($urandom), 16'sd2000, -16'sd2000,
                             cos2fit_pkg::cost_mode_type'($urandom_range(0, 1)));
         endcase
         run_phase(75);
      end

      if (cost_sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
